// ----- design/ptd_pkg.sv -----
// ----------------------------------------------------------------------------
// ptd_pkg: shared types and widths of the point to triangle distance unit
// Payload structs, region codes and the internal word widths of the pipeline.
// ----------------------------------------------------------------------------
package ptd_pkg;

  // coordinate and difference widths
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  // digit width of the pipelined multipliers
  localparam int MUL_DIG   = 16;
  // dot products of differences, triangle normal components
  localparam int DOT_W     = 2 * DIFF_W + 2;
  localparam int NRM_W     = 2 * DIFF_W + 1;
  // operands of the second multiplier tier
  localparam int OPB_W     = DOT_W + 1;
  // normal dot ap, its square, and the distance denominator
  localparam int NP_W      = 103;
  localparam int NUM_W     = 2 * NP_W;
  localparam int DEN_W     = 136;
  // result bits of the root
  localparam int ROOT_BITS = 32;

  typedef enum logic [2:0] {
    REGION_A    = 3'd0,
    REGION_B    = 3'd1,
    REGION_AB   = 3'd2,
    REGION_C    = 3'd3,
    REGION_AC   = 3'd4,
    REGION_BC   = 3'd5,
    REGION_FACE = 3'd6
  } region_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
  } req_t;

  typedef struct packed {
    logic [ROOT_BITS-1:0] distance;
    region_t              region;
  } rsp_t;

endpackage

// ----- design/point_triangle_distance_unit.sv -----
// ----------------------------------------------------------------------------
// point_triangle_distance_unit: distance from a point to a triangle
// Voronoi region tests, exact wide arithmetic, truncated root of the
// squared distance, saturated at the largest value.
//
//   channel  direction  handshake             payload
//   req      in         req_valid / req_stall  req_t (p, a, b, c)
//   rsp      out        rsp_valid / rsp_stall  rsp_t (distance, region)
//
// one transaction per cycle while the output is not stalled; difference register,
// three multiplier tiers (one 16-bit digit a stage)
// with a sum register after the first two, and 32 root stages
// reset clears the valid bits only
// a stalled output freezes the whole pipeline, so req_stall follows it
// ----------------------------------------------------------------------------
module point_triangle_distance_unit import ptd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int LAT_A = (DIFF_W + MUL_DIG - 1) / MUL_DIG + 2;
  localparam int LAT_B = (OPB_W + MUL_DIG - 1) / MUL_DIG + 2;
  localparam int LAT_C = (NP_W + MUL_DIG - 1) / MUL_DIG + 2;
  localparam int PA_W  = 2 * DIFF_W;
  localparam int PB_W  = 2 * OPB_W;
  localparam int VW    = PB_W + 1;
  localparam int SW    = PB_W + 2;
  // difference vectors: ab, ac, bc, ap, bp, cp
  localparam int V_AB = 0, V_AC = 1, V_BC = 2, V_AP = 3, V_BP = 4, V_CP = 5;
  // dot products
  localparam int D1 = 0, D2 = 1, D3 = 2, D4 = 3, D5 = 4, D6 = 5;
  localparam int APAP = 6, BPBP = 7, CPCP = 8, ABAB = 9, ACAC = 10, BCBC = 11;
  localparam int NDOT = 12;
  localparam int NMB  = 18;
  localparam int DOT_U [NDOT] = '{V_AB, V_AC, V_AB, V_AC, V_AB, V_AC,
                                  V_AP, V_BP, V_CP, V_AB, V_AC, V_BC};
  localparam int DOT_V [NDOT] = '{V_AP, V_AP, V_BP, V_BP, V_CP, V_CP,
                                  V_AP, V_BP, V_CP, V_AB, V_AC, V_BC};

  typedef struct packed {
    region_t          rg;
    logic             sq;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } sel_t;

  logic en;

  // whole pipeline moves unless the output holds a stalled transaction
  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  // ---------------- stage 1: differences ----------------
  logic signed [COORD_W-1:0] crd_p [3], crd_a [3], crd_b [3], crd_c [3];
  logic signed [DIFF_W-1:0]  vec [6][3];
  logic                      v1;

  always_comb begin
    crd_p[0] = req.px; crd_p[1] = req.py;       crd_p[2] = req.pz;
    crd_a[0] = req.ax; crd_a[1] = req.ay;       crd_a[2] = req.az;
    crd_b[0] = req.bx; crd_b[1] = req.by_coord; crd_b[2] = req.bz;
    crd_c[0] = req.cx; crd_c[1] = req.cy;       crd_c[2] = req.cz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int h = 0; h < 3; h++) begin
        vec[V_AB][h] <= DIFF_W'(crd_b[h]) - DIFF_W'(crd_a[h]);
        vec[V_AC][h] <= DIFF_W'(crd_c[h]) - DIFF_W'(crd_a[h]);
        vec[V_BC][h] <= DIFF_W'(crd_c[h]) - DIFF_W'(crd_b[h]);
        vec[V_AP][h] <= DIFF_W'(crd_p[h]) - DIFF_W'(crd_a[h]);
        vec[V_BP][h] <= DIFF_W'(crd_p[h]) - DIFF_W'(crd_b[h]);
        vec[V_CP][h] <= DIFF_W'(crd_p[h]) - DIFF_W'(crd_c[h]);
      end
    end
  end

  // ---------------- tier A: component products ----------------
  logic signed [PA_W-1:0] pa_dot [NDOT][3];
  logic signed [PA_W-1:0] pa_cr [3][2];

  for (genvar g = 0; g < NDOT; g++) begin : g_dot
    for (genvar h = 0; h < 3; h++) begin : g_cmp
      ptd_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_mul (
        .clk (clk), .en (en),
        .a   (vec[DOT_U[g]][h]),
        .b   (vec[DOT_V[g]][h]),
        .p   (pa_dot[g][h])
      );
    end
  end

  // cross product terms of ab x ac
  for (genvar h = 0; h < 3; h++) begin : g_cross
    ptd_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_mul0 (
      .clk (clk), .en (en),
      .a   (vec[V_AB][(h + 1) % 3]),
      .b   (vec[V_AC][(h + 2) % 3]),
      .p   (pa_cr[h][0])
    );
    ptd_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_mul1 (
      .clk (clk), .en (en),
      .a   (vec[V_AB][(h + 2) % 3]),
      .b   (vec[V_AC][(h + 1) % 3]),
      .p   (pa_cr[h][1])
    );
  end

  // ap and valid ride along tier A
  logic [LAT_A-1:0]             va_sh;
  logic [2:0][DIFF_W-1:0]       ap_sh [LAT_A];

  always_ff @(posedge clk) begin
    if (rst) begin
      va_sh <= '0;
    end else if (en) begin
      va_sh <= {va_sh[LAT_A-2:0], v1};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ap_sh[0] <= {vec[V_AP][2], vec[V_AP][1], vec[V_AP][0]};
      for (int i = 1; i < LAT_A; i++) begin
        ap_sh[i] <= ap_sh[i-1];
      end
    end
  end

  // ---------------- stage 2: dot sums and normal ----------------
  logic signed [DOT_W-1:0] dot [NDOT];
  logic signed [NRM_W-1:0] nrm [3];
  logic [2:0][DIFF_W-1:0]  ap2;
  logic                    v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= va_sh[LAT_A-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NDOT; g++) begin
        dot[g] <= DOT_W'(pa_dot[g][0]) + DOT_W'(pa_dot[g][1]) + DOT_W'(pa_dot[g][2]);
      end
      for (int h = 0; h < 3; h++) begin
        nrm[h] <= NRM_W'(pa_cr[h][0]) - NRM_W'(pa_cr[h][1]);
      end
      ap2 <= ap_sh[LAT_A-1];
    end
  end

  // ---------------- tier B: products of dot products ----------------
  logic signed [OPB_W-1:0] opa [NMB], opb [NMB];
  logic signed [OPB_W-1:0] e_bc;
  logic signed [PB_W-1:0]  pb [NMB];

  always_comb begin
    e_bc    = OPB_W'(dot[D4]) - OPB_W'(dot[D3]);
    opa[0]  = OPB_W'(dot[D1]);   opb[0]  = OPB_W'(dot[D4]);
    opa[1]  = OPB_W'(dot[D3]);   opb[1]  = OPB_W'(dot[D2]);
    opa[2]  = OPB_W'(dot[D5]);   opb[2]  = OPB_W'(dot[D2]);
    opa[3]  = OPB_W'(dot[D1]);   opb[3]  = OPB_W'(dot[D6]);
    opa[4]  = OPB_W'(dot[D3]);   opb[4]  = OPB_W'(dot[D6]);
    opa[5]  = OPB_W'(dot[D5]);   opb[5]  = OPB_W'(dot[D4]);
    opa[6]  = OPB_W'(dot[D1]);   opb[6]  = OPB_W'(dot[D1]);
    opa[7]  = OPB_W'(dot[D2]);   opb[7]  = OPB_W'(dot[D2]);
    opa[8]  = e_bc;              opb[8]  = e_bc;
    opa[9]  = OPB_W'(dot[APAP]); opb[9]  = OPB_W'(dot[ABAB]);
    opa[10] = OPB_W'(dot[APAP]); opb[10] = OPB_W'(dot[ACAC]);
    opa[11] = OPB_W'(dot[BPBP]); opb[11] = OPB_W'(dot[BCBC]);
    for (int h = 0; h < 3; h++) begin
      opa[12+h] = OPB_W'(nrm[h]);
      opb[12+h] = OPB_W'(nrm[h]);
      opa[15+h] = OPB_W'(nrm[h]);
      opb[15+h] = OPB_W'($signed(ap2[h]));
    end
  end

  for (genvar g = 0; g < NMB; g++) begin : g_mb
    ptd_mul #(.WA(OPB_W), .WB(OPB_W)) u_mul (
      .clk (clk), .en (en),
      .a   (opa[g]),
      .b   (opb[g]),
      .p   (pb[g])
    );
  end

  // dot products and valid ride along tier B
  logic [LAT_B-1:0]              vb_sh;
  logic [NDOT-1:0][DOT_W-1:0]    dsh [LAT_B];

  always_ff @(posedge clk) begin
    if (rst) begin
      vb_sh <= '0;
    end else if (en) begin
      vb_sh <= {vb_sh[LAT_B-2:0], v2};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NDOT; g++) begin
        dsh[0][g] <= dot[g];
      end
      for (int i = 1; i < LAT_B; i++) begin
        dsh[i] <= dsh[i-1];
      end
    end
  end

  // ---------------- stage 3: region tests and selection ----------------
  logic signed [DOT_W-1:0] dd [NDOT];
  logic signed [VW-1:0]    vc_s, vb_s, va_s, nab, nac, nbc;
  logic signed [SW-1:0]    nn_s, np_s;
  region_t                 rg_s;
  logic                    sq_s;
  logic [NUM_W-1:0]        num_s;
  logic [DEN_W-1:0]        den_s;

  always_comb begin
    for (int g = 0; g < NDOT; g++) begin
      dd[g] = $signed(dsh[LAT_B-1][g]);
    end
    vc_s = VW'(pb[0]) - VW'(pb[1]);
    vb_s = VW'(pb[2]) - VW'(pb[3]);
    va_s = VW'(pb[4]) - VW'(pb[5]);
    nab  = VW'(pb[9]) - VW'(pb[6]);
    nac  = VW'(pb[10]) - VW'(pb[7]);
    nbc  = VW'(pb[11]) - VW'(pb[8]);
    nn_s = SW'(pb[12]) + SW'(pb[13]) + SW'(pb[14]);
    np_s = SW'(pb[15]) + SW'(pb[16]) + SW'(pb[17]);

    sq_s  = 1'b0;
    den_s = DEN_W'(1);
    num_s = NUM_W'($unsigned(dd[APAP]));
    if (dd[D1] <= 0 && dd[D2] <= 0) begin
      rg_s = REGION_A;
    end else if (dd[D3] >= 0 && dd[D4] <= dd[D3]) begin
      rg_s  = REGION_B;
      num_s = NUM_W'($unsigned(dd[BPBP]));
    end else if (vc_s <= 0 && dd[D1] >= 0 && dd[D3] <= 0) begin
      rg_s = REGION_AB;
      if (dd[ABAB] != 0) begin
        num_s = NUM_W'($unsigned(nab));
        den_s = DEN_W'($unsigned(dd[ABAB]));
      end
    end else if (dd[D6] >= 0 && dd[D5] <= dd[D6]) begin
      rg_s  = REGION_C;
      num_s = NUM_W'($unsigned(dd[CPCP]));
    end else if (vb_s <= 0 && dd[D2] >= 0 && dd[D6] <= 0) begin
      rg_s = REGION_AC;
      if (dd[ACAC] != 0) begin
        num_s = NUM_W'($unsigned(nac));
        den_s = DEN_W'($unsigned(dd[ACAC]));
      end
    end else if (va_s <= 0 && dd[D4] >= dd[D3] && dd[D5] >= dd[D6]) begin
      rg_s = REGION_BC;
      if (dd[BCBC] != 0) begin
        num_s = NUM_W'($unsigned(nbc));
        den_s = DEN_W'($unsigned(dd[BCBC]));
      end else begin
        num_s = NUM_W'($unsigned(dd[BPBP]));
      end
    end else begin
      // face, or vertex a when the triangle has no area
      rg_s = REGION_FACE;
      if (nn_s != 0) begin
        sq_s  = 1'b1;
        den_s = DEN_W'($unsigned(nn_s));
      end
    end
  end

  logic                   v3;
  sel_t                   sel3;
  logic signed [NP_W-1:0] np3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vb_sh[LAT_B-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel3.rg  <= rg_s;
      sel3.sq  <= sq_s;
      sel3.num <= num_s;
      sel3.den <= den_s;
      np3      <= $signed(np_s[NP_W-1:0]);
    end
  end

  // ---------------- tier C: square of normal dot ap ----------------
  logic signed [NUM_W-1:0] sqr;
  logic [LAT_C-1:0]        vcc_sh;
  sel_t                    sel_sh [LAT_C];

  ptd_mul #(.WA(NP_W), .WB(NP_W)) u_sqr (
    .clk (clk), .en (en),
    .a   (np3),
    .b   (np3),
    .p   (sqr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vcc_sh <= '0;
    end else if (en) begin
      vcc_sh <= {vcc_sh[LAT_C-2:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_sh[0] <= sel3;
      for (int i = 1; i < LAT_C; i++) begin
        sel_sh[i] <= sel_sh[i-1];
      end
    end
  end

  // ---------------- root stages ----------------
  logic [NUM_W-1:0] num4;

  assign num4 = sel_sh[LAT_C-1].sq ? $unsigned(sqr) : sel_sh[LAT_C-1].num;

  ptd_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vcc_sh[LAT_C-1]),
    .in_region (sel_sh[LAT_C-1].rg),
    .in_num    (num4),
    .in_den    (sel_sh[LAT_C-1].den),
    .out_valid (rsp_valid),
    .out_rsp   (rsp)
  );

endmodule

// ----- design/ptd_mul.sv -----
// ----------------------------------------------------------------------------
// ptd_mul: pipelined signed multiplier
// Sign-magnitude, one 16-bit digit of b per stage, between an entry and a sign stage.
// ----------------------------------------------------------------------------
module ptd_mul import ptd_pkg::*; #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [WA-1:0]  a,
  input  logic signed [WB-1:0]  b,
  output logic signed [WA+WB-1:0] p
);

  localparam int N   = (WB + MUL_DIG - 1) / MUL_DIG;
  localparam int WBP = N * MUL_DIG;
  localparam int WP  = WA + WB;
  localparam int PPW = WA + MUL_DIG;

  logic [WA-1:0]  ma [N];
  logic [WBP-1:0] mb [N];
  logic           ng [N+1];
  logic [WP-1:0]  acc [N+1];
  logic [PPW-1:0] pp [N];
  logic [WA-1:0]  amag;
  logic [WB-1:0]  bmag;

  // operand magnitudes
  always_comb begin
    amag = a[WA-1] ? $unsigned(-a) : $unsigned(a);
    bmag = b[WB-1] ? $unsigned(-b) : $unsigned(b);
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (en) begin
      ma[0]  <= amag;
      mb[0]  <= WBP'(bmag);
      ng[0]  <= a[WA-1] ^ b[WB-1];
      acc[0] <= '0;
    end
  end

  // one digit per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    assign pp[i] = PPW'(ma[i]) * PPW'(mb[i][i*MUL_DIG +: MUL_DIG]);
    always_ff @(posedge clk) begin
      if (en) begin
        acc[i+1] <= acc[i] + (WP'(pp[i]) << (i * MUL_DIG));
        ng[i+1]  <= ng[i];
      end
    end
    if (i < N - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          ma[i+1] <= ma[i];
          mb[i+1] <= mb[i];
        end
      end
    end
  end

  // apply sign
  always_ff @(posedge clk) begin
    if (en) begin
      p <= ng[N] ? -$signed(acc[N]) : $signed(acc[N]);
    end
  end

endmodule

// ----- design/ptd_root.sv -----
// ----------------------------------------------------------------------------
// ptd_root: pipelined floor(sqrt(num / den))
// One result bit per stage; keeps num - s*s*den and s*den so each stage
// is a shifted add and one compare.
// ----------------------------------------------------------------------------
module ptd_root import ptd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  region_t          in_region,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  output logic             out_valid,
  output rsp_t             out_rsp
);

  localparam int QD_W = DEN_W + ROOT_BITS;
  localparam int TW   = NUM_W + 1;

  logic [NUM_W-1:0]     rem [ROOT_BITS+1];
  logic [QD_W-1:0]      qd  [ROOT_BITS+1];
  logic [DEN_W-1:0]     dn  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] sr  [ROOT_BITS+1];
  region_t              rg  [ROOT_BITS+1];
  logic                 vl  [ROOT_BITS+1];

  // stage inputs
  always_comb begin
    rem[0] = in_num;
    qd[0]  = '0;
    dn[0]  = in_den;
    sr[0]  = '0;
    rg[0]  = in_region;
    vl[0]  = in_valid;
  end

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_bit
    localparam int K = ROOT_BITS - 1 - i;
    logic [TW-1:0] trial;
    logic          take;

    // trial of setting bit K
    always_comb begin
      trial = (TW'(qd[i]) << (K + 1)) + (TW'(dn[i]) << (2 * K));
      take  = trial <= TW'(rem[i]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else if (en) begin
        vl[i+1] <= vl[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= take ? NUM_W'(TW'(rem[i]) - trial) : rem[i];
        qd[i+1]  <= take ? qd[i] + (QD_W'(dn[i]) << K) : qd[i];
        sr[i+1]  <= take ? (sr[i] | (ROOT_BITS'(1) << K)) : sr[i];
        dn[i+1]  <= dn[i];
        rg[i+1]  <= rg[i];
      end
    end
  end

  assign out_valid        = vl[ROOT_BITS];
  assign out_rsp.distance = sr[ROOT_BITS];
  assign out_rsp.region   = rg[ROOT_BITS];

endmodule
